// File: design/alunzcv_pkg.sv
// ----------------------------------------------------------------------------
// alunzcv_pkg: shared types and constants for the NZCV flag ALU
// Holds the request and result structs, the opcodes, the sequencer states and
// the control bundle that runs between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package alunzcv_pkg;

  localparam int WORD_W   = 16;
  localparam int FUNC_W   = 4;
  localparam int CNT_W    = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  localparam logic [FUNC_W-1:0] OP_ADD = 4'd0;
  localparam logic [FUNC_W-1:0] OP_SUB = 4'd1;
  localparam logic [FUNC_W-1:0] OP_MUL = 4'd2;
  localparam logic [FUNC_W-1:0] OP_DIV = 4'd3;
  localparam logic [FUNC_W-1:0] OP_AND = 4'd4;
  localparam logic [FUNC_W-1:0] OP_OR  = 4'd5;
  localparam logic [FUNC_W-1:0] OP_NOT = 4'd6;
  localparam logic [FUNC_W-1:0] OP_XOR = 4'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
  } alunzcv_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic [WORD_W-1:0] remainder;
    logic              flag_negative;
    logic              flag_zero;
    logic              flag_carry;
    logic              flag_overflow;
    logic              op_valid;
  } alunzcv_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } alunzcv_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fin;
  } alunzcv_ctl_t;

endpackage

// File: design/alu_with_nzcv_flags.sv
// Each request takes 16 bit steps of the serial datapath and then a finish
//   state, in which the next request may start.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset (rst_n low, synchronous) returns the sequencer to idle, drops the
//   strobe and clears the stored NZCV flags.
// ----------------------------------------------------------------------------
// alu_with_nzcv_flags: bit-serial word ALU with stored NZCV flags
// Add, sub, low-word mul, unsigned div with remainder, and, or, not, xor.
// A valid op rewrites the flags; an invalid op reports them unchanged.
// ----------------------------------------------------------------------------
module alu_with_nzcv_flags (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel: accepted when start is high and busy is low
  input  logic                      start,
  output logic                      busy,
  input  alunzcv_pkg::alunzcv_in_t  in_data,
  // result channel: one-cycle strobe
  output logic                      out_valid,
  output alunzcv_pkg::alunzcv_out_t out_data
);
  import alunzcv_pkg::*;

  // control bundle: load on accept, step per bit, finish after the last step
  alunzcv_ctl_t ctl;

  // sequencer: hold busy during the bit steps, advance the step count
  alunzcv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  // datapath: shift operands one bit per step, then register result and flags
  alunzcv_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");
  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ctl.fin))
    else $error("result strobe without finish cycle");
  a_no_strobe_mid: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> !out_valid)
    else $error("result strobe in the middle of the steps");
`endif

endmodule

// File: design/alunzcv_ctrl.sv
// ----------------------------------------------------------------------------
// alunzcv_ctrl: request sequencer
// Counts the bit steps of one request and flags the load and finish cycles.
// ----------------------------------------------------------------------------
module alunzcv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output alunzcv_pkg::alunzcv_ctl_t ctl
);
  import alunzcv_pkg::*;

  alunzcv_state_t   state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    busy      = 1'b0;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        busy     = 1'b1;
        ctl.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // finish this request and take the next one in the same cycle
        ctl.fin = 1'b1;
        if (start) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_to_run: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (state_r == ST_RUN) && (cnt_r == '0))
    else $error("load did not enter the step phase");
  a_run_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (cnt_r == CNT_LAST) |=> ctl.fin)
    else $error("last step not followed by finish");
  a_fin_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin |-> $past(ctl.step))
    else $error("finish without a preceding step");
`endif

endmodule

// File: design/alunzcv_dpath.sv
// ----------------------------------------------------------------------------
// alunzcv_dpath: bit-serial datapath and flag register
// Shift registers take one bit per step for add, sub and logic ops; mul and
// div run shift-add and restoring shift-subtract over the same steps.
// ----------------------------------------------------------------------------
module alunzcv_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  alunzcv_pkg::alunzcv_ctl_t   ctl,
  input  alunzcv_pkg::alunzcv_in_t    in_data,
  output logic                        out_valid,
  output alunzcv_pkg::alunzcv_out_t   out_data
);
  import alunzcv_pkg::*;

  logic [FUNC_W-1:0] func_r;
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic              c_r, c_nxt;
  logic              v_r, v_nxt;
  logic [3:0]        flags_r;
  logic              out_valid_r;
  alunzcv_out_t      out_r, out_nxt;

  logic              bit_a, bit_b, bit_s;
  logic [WORD_W+1:0] trial;
  logic              ge;
  logic [WORD_W-1:0] res;
  logic              valid;
  logic              is_arith;

  // one bit step
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    c_nxt   = c_r;
    v_nxt   = v_r;
    bit_a   = a_r[0];
    bit_b   = (func_r == OP_SUB) ? ~b_r[0] : b_r[0];
    bit_s   = 1'b0;
    trial   = {1'b0, rem_r, a_r[WORD_W-1]} - {2'b00, b_r};
    ge      = ~trial[WORD_W+1];
    case (func_r)
      OP_ADD, OP_SUB: begin
        bit_s = bit_a ^ bit_b ^ c_r;
        c_nxt = (bit_a & bit_b) | (bit_a & c_r) | (bit_b & c_r);
        v_nxt = c_r ^ c_nxt;
      end
      OP_AND:  bit_s = bit_a & bit_b;
      OP_OR:   bit_s = bit_a | bit_b;
      OP_NOT:  bit_s = ~bit_a;
      OP_XOR:  bit_s = bit_a ^ bit_b;
      default: bit_s = 1'b0;
    endcase
    case (func_r)
      OP_MUL: begin
        acc_nxt = b_r[0] ? acc_r + a_r : acc_r;
        a_nxt   = {a_r[WORD_W-2:0], 1'b0};
        b_nxt   = {1'b0, b_r[WORD_W-1:1]};
      end
      OP_DIV: begin
        rem_nxt = ge ? trial[WORD_W-1:0] : {rem_r[WORD_W-2:0], a_r[WORD_W-1]};
        a_nxt   = {a_r[WORD_W-2:0], ge};
      end
      default: begin
        acc_nxt = {bit_s, acc_r[WORD_W-1:1]};
        a_nxt   = {1'b0, a_r[WORD_W-1:1]};
        b_nxt   = {1'b0, b_r[WORD_W-1:1]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func_r <= in_data.func;
      a_r    <= in_data.operand_a;
      b_r    <= in_data.operand_b;
      acc_r  <= '0;
      rem_r  <= (in_data.func == OP_DIV) ? '0 : in_data.operand_a;
      c_r    <= (in_data.func == OP_SUB);
      v_r    <= 1'b0;
    end else if (ctl.step) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      c_r    <= c_nxt;
      v_r    <= v_nxt;
    end
  end

  // finish: form the result and the flags
  always_comb begin
    valid    = func_r inside {[OP_ADD:OP_XOR]};
    is_arith = (func_r == OP_ADD) || (func_r == OP_SUB);
    if (!valid) begin
      res = '0;
    end else if (func_r == OP_DIV) begin
      res = a_r;
    end else begin
      res = acc_r;
    end
    out_nxt.result    = res;
    out_nxt.remainder = rem_r;
    out_nxt.op_valid  = valid;
    if (valid) begin
      out_nxt.flag_negative = res[WORD_W-1];
      out_nxt.flag_zero     = (res == '0);
      out_nxt.flag_carry    = is_arith & (c_r ^ (func_r == OP_SUB));
      out_nxt.flag_overflow = is_arith & v_r;
    end else begin
      out_nxt.flag_negative = flags_r[0];
      out_nxt.flag_zero     = flags_r[1];
      out_nxt.flag_carry    = flags_r[2];
      out_nxt.flag_overflow = flags_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.fin;
      if (ctl.fin) begin
        flags_r <= {out_nxt.flag_overflow, out_nxt.flag_carry,
                    out_nxt.flag_zero, out_nxt.flag_negative};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> {out_r.flag_overflow, out_r.flag_carry, out_r.flag_zero,
                     out_r.flag_negative} == flags_r)
    else $error("reported flags differ from flag register");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.op_valid |-> (out_r.result == '0) && $stable(flags_r))
    else $error("invalid opcode changed flags or gave nonzero result");
  a_logic_no_cv: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin && (func_r == OP_AND || func_r == OP_OR || func_r == OP_NOT ||
                func_r == OP_XOR || func_r == OP_MUL || func_r == OP_DIV)
    |=> !out_r.flag_carry && !out_r.flag_overflow)
    else $error("C or V set by an op that clears them");
`endif

endmodule
